### rtl/ffp_pkg.sv
// Package for the XOR-checked frame parser: shared types, codes and constants.
// Depends on nothing; every other file of the block but the checker refers to it by scoped names.
`default_nettype none

package ffp_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_START_BYTE    = 3'd0;
  localparam logic [2:0] REG_CODE_IDENTIFY = 3'd1;
  localparam logic [2:0] REG_CODE_DUMP     = 3'd2;
  localparam logic [2:0] REG_CODE_ACK      = 3'd3;
  localparam logic [2:0] REG_CODE_NACK     = 3'd4;
  localparam logic [2:0] REG_IDENTIFY_SIZE = 3'd5;
  localparam logic [2:0] REG_MAX_PAYLOAD   = 3'd6;

  // Length rules for dump frames (a minimum) and nack frames (a fixed length).
  localparam logic [15:0] DUMP_MIN_LEN = 16'd5;
  localparam logic [15:0] NACK_LEN     = 16'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CODE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    KIND_IDENTIFY = 2'd0,
    KIND_DUMP     = 2'd1,
    KIND_ACK      = 2'd2,
    KIND_NACK     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_GOOD      = 2'd1,
    ST_CSUM_ERR  = 2'd2,
    ST_LEN_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  code_identify;
    logic [7:0]  code_dump;
    logic [7:0]  code_ack;
    logic [7:0]  code_nack;
    logic [15:0] identify_size;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    status_t     frame_status;
    kind_t       frame_kind;
    logic [15:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

### rtl/xor_checked_frame_parser_unit.sv
// Top level of the XOR-checked frame parser: register file, state machine, result register.
// Depends on ffp_pkg, ffp_cfg_regs, ffp_core and ffp_out_reg.
//
//   Channel   Signals                                   Role
//   input     in_valid, in_ready, rx_byte               one received byte per transfer
//   output    out_valid, out_ready, result fields       one result per input transfer
//   config    psel, penable, pwrite, paddr, pwdata,     APB-style register access,
//             prdata, pready                            registers at byte address 4*i
//
// Every received byte passes through the frame state machine and lands in the result
// register at the edge at which it is accepted, so its result shows in the next cycle. A
// new byte is taken in every cycle as long as the result register is empty or is being
// drained in the same cycle. A stall at the output holds the result and blocks the input
// only while the result register is full. Reset is synchronous and puts the parser back
// to hunting with state, valid flag and configuration at defaults, but not the result data.
`default_nettype none

module xor_checked_frame_parser_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Received byte stream.
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 rx_byte,
  // Result stream.
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            is_payload,
  output logic      [7:0]                 payload_byte,
  output logic      [15:0]                payload_index,
  output logic                            frame_end,
  output logic      [1:0]                 frame_status,
  output logic      [1:0]                 frame_kind,
  output logic      [15:0]                frame_length,
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ffp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ffp_pkg::DATA_W-1:0] pwdata,
  output logic      [ffp_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  ffp_pkg::cfg_t cfg;
  ffp_pkg::res_t res_comb;
  ffp_pkg::res_t res_q;
  logic          accept;

  // The state machine advances exactly on an input transfer.
  assign accept = in_valid && in_ready;

  ffp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res_comb)
  );

  ffp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_comb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  // Unpack the registered result onto the field ports.
  assign is_payload    = res_q.is_payload;
  assign payload_byte  = res_q.payload_byte;
  assign payload_index = res_q.payload_index;
  assign frame_end     = res_q.frame_end;
  assign frame_status  = res_q.frame_status;
  assign frame_kind    = res_q.frame_kind;
  assign frame_length  = res_q.frame_length;

endmodule

`default_nettype wire

### rtl/ffp_cfg_regs.sv
// Configuration register file of the frame parser behind an APB-style port.
// Depends on ffp_pkg for the register indexes and the configuration struct.
`default_nettype none

module ffp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ffp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ffp_pkg::DATA_W-1:0] pwdata,
  output logic      [ffp_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ffp_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= 8'd0;
      cfg.code_identify <= 8'd1;
      cfg.code_dump     <= 8'd2;
      cfg.code_ack      <= 8'd3;
      cfg.code_nack     <= 8'd4;
      cfg.identify_size <= 16'd0;
      cfg.max_payload   <= 16'hFFFF;
    end else if (wr_en) begin
      case (idx)
        ffp_pkg::REG_START_BYTE:    cfg.start_byte    <= pwdata[7:0];
        ffp_pkg::REG_CODE_IDENTIFY: cfg.code_identify <= pwdata[7:0];
        ffp_pkg::REG_CODE_DUMP:     cfg.code_dump     <= pwdata[7:0];
        ffp_pkg::REG_CODE_ACK:      cfg.code_ack      <= pwdata[7:0];
        ffp_pkg::REG_CODE_NACK:     cfg.code_nack     <= pwdata[7:0];
        ffp_pkg::REG_IDENTIFY_SIZE: cfg.identify_size <= pwdata[15:0];
        ffp_pkg::REG_MAX_PAYLOAD:   cfg.max_payload   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ffp_pkg::REG_START_BYTE:    prdata = {24'd0, cfg.start_byte};
      ffp_pkg::REG_CODE_IDENTIFY: prdata = {24'd0, cfg.code_identify};
      ffp_pkg::REG_CODE_DUMP:     prdata = {24'd0, cfg.code_dump};
      ffp_pkg::REG_CODE_ACK:      prdata = {24'd0, cfg.code_ack};
      ffp_pkg::REG_CODE_NACK:     prdata = {24'd0, cfg.code_nack};
      ffp_pkg::REG_IDENTIFY_SIZE: prdata = {16'd0, cfg.identify_size};
      ffp_pkg::REG_MAX_PAYLOAD:   prdata = {16'd0, cfg.max_payload};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ffp_core.sv
// Frame state machine of the parser: phase, running checksum, kind, length, count.
// Produces one result per byte combinationally; depends on ffp_pkg.
`default_nettype none

module ffp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [7:0]    rx_byte,
  input  wire ffp_pkg::cfg_t cfg,
  output ffp_pkg::res_t      res
);

  ffp_pkg::phase_t phase, phase_next;
  ffp_pkg::kind_t  kind, kind_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [15:0]     declared_length, declared_length_next;
  logic [15:0]     received_count, received_count_next;

  logic            code_known;
  ffp_pkg::kind_t  code_kind;
  logic [15:0]     count_inc;
  logic [15:0]     full_length;
  logic            length_ok;

  // Code lookup with identify, dump, ack, nack priority.
  always_comb begin
    code_known = 1'b1;
    code_kind  = ffp_pkg::KIND_IDENTIFY;
    if (rx_byte == cfg.code_identify)  code_kind = ffp_pkg::KIND_IDENTIFY;
    else if (rx_byte == cfg.code_dump) code_kind = ffp_pkg::KIND_DUMP;
    else if (rx_byte == cfg.code_ack)  code_kind = ffp_pkg::KIND_ACK;
    else if (rx_byte == cfg.code_nack) code_kind = ffp_pkg::KIND_NACK;
    else                               code_known = 1'b0;
  end

  assign count_inc   = received_count + 16'd1;
  assign full_length = {rx_byte, declared_length[7:0]};

  always_comb begin
    case (kind)
      ffp_pkg::KIND_IDENTIFY: length_ok = (declared_length == cfg.identify_size);
      ffp_pkg::KIND_DUMP:     length_ok = (declared_length >= ffp_pkg::DUMP_MIN_LEN);
      ffp_pkg::KIND_ACK:      length_ok = (declared_length == 16'd0);
      default:                length_ok = (declared_length == ffp_pkg::NACK_LEN);
    endcase
    if (declared_length > cfg.max_payload) length_ok = 1'b0;
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    case (phase)
      ffp_pkg::PH_HUNT: begin
        if (rx_byte == cfg.start_byte) phase_next = ffp_pkg::PH_CODE;
      end
      ffp_pkg::PH_CODE:    phase_next = code_known ? ffp_pkg::PH_LEN_LO : ffp_pkg::PH_HUNT;
      ffp_pkg::PH_LEN_LO:  phase_next = ffp_pkg::PH_LEN_HI;
      ffp_pkg::PH_LEN_HI: begin
        phase_next = (full_length != 16'd0) ? ffp_pkg::PH_PAYLOAD : ffp_pkg::PH_CHECK;
      end
      ffp_pkg::PH_PAYLOAD: begin
        if (count_inc == declared_length) phase_next = ffp_pkg::PH_CHECK;
      end
      default:             phase_next = ffp_pkg::PH_HUNT;
    endcase
  end

  // Data registers that travel with the frame.
  always_comb begin
    running_xor_next     = running_xor;
    kind_next            = kind;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    case (phase)
      ffp_pkg::PH_HUNT: begin
        if (rx_byte == cfg.start_byte) running_xor_next = rx_byte;
      end
      ffp_pkg::PH_CODE: begin
        if (code_known) begin
          kind_next        = code_kind;
          running_xor_next = running_xor ^ rx_byte;
        end
      end
      ffp_pkg::PH_LEN_LO: begin
        declared_length_next = {8'd0, rx_byte};
        running_xor_next     = running_xor ^ rx_byte;
      end
      ffp_pkg::PH_LEN_HI: begin
        declared_length_next = full_length;
        running_xor_next     = running_xor ^ rx_byte;
        received_count_next  = 16'd0;
      end
      ffp_pkg::PH_PAYLOAD: begin
        running_xor_next    = running_xor ^ rx_byte;
        received_count_next = count_inc;
      end
      default: ;
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res = '0;
    case (phase)
      ffp_pkg::PH_PAYLOAD: begin
        res.is_payload    = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = received_count;
      end
      ffp_pkg::PH_CHECK: begin
        res.frame_end    = 1'b1;
        res.frame_kind   = kind;
        res.frame_length = declared_length;
        if (rx_byte != running_xor) res.frame_status = ffp_pkg::ST_CSUM_ERR;
        else if (!length_ok)        res.frame_status = ffp_pkg::ST_LEN_ERR;
        else                        res.frame_status = ffp_pkg::ST_GOOD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ffp_pkg::PH_HUNT;
      running_xor     <= 8'd0;
      kind            <= ffp_pkg::KIND_IDENTIFY;
      declared_length <= 16'd0;
      received_count  <= 16'd0;
    end else if (advance) begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      kind            <= kind_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ffp_out_reg.sv
// Result register of the frame parser with its valid/ready handshake.
// Depends on ffp_pkg for the result struct.
`default_nettype none

module ffp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ffp_pkg::res_t res_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffp_pkg::res_t      res_out
);

  logic load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

### rtl/ffp_checker.sv
// Port-level checker for the frame parser and the bind that attaches it to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ffp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        is_payload,
  input wire logic [7:0]  payload_byte,
  input wire logic [15:0] payload_index,
  input wire logic        frame_end,
  input wire logic [1:0]  frame_status,
  input wire logic [1:0]  frame_kind,
  input wire logic [15:0] frame_length
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_index) && $stable(frame_status))
    else $error("result changed while stalled");

  // An empty result register must always take a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // A byte cannot be both payload and checksum.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_payload && frame_end))
    else $error("payload and frame end at once");

  // Outside a frame end the verdict fields are zero, and a frame end has a verdict.
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end ? (frame_status != 2'd0)
                             : (frame_status == 2'd0 && frame_kind == 2'd0
                                && frame_length == 16'd0)))
    else $error("verdict fields inconsistent with frame_end");

  // Payload fields are zero unless the byte was payload.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload |-> payload_byte == 8'd0 && payload_index == 16'd0)
    else $error("payload fields set on a non-payload result");

endmodule

bind xor_checked_frame_parser_unit ffp_checker u_ffp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_payload    (is_payload),
  .payload_byte  (payload_byte),
  .payload_index (payload_index),
  .frame_end     (frame_end),
  .frame_status  (frame_status),
  .frame_kind    (frame_kind),
  .frame_length  (frame_length)
);

`default_nettype wire
